@@ rtl/lmbpw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmbpw_pkg
// Types and constants shared by the bitplane pixel writer: payload structs,
// configuration register map, drive word layout and the sequencer states.
// ----------------------------------------------------------------------------
package lmbpw_pkg;

  localparam int CoordWidth  = 16;
  localparam int LevelWidth  = 8;
  localparam int WordWidth   = 13;
  localparam int ColCfgWidth = 8;
  localparam int CfgIdxWidth = 3;
  localparam int LaneWidth   = 3;
  localparam int RowAddrWidth = 5;

  // Configuration register indices
  localparam logic [CfgIdxWidth-1:0] CFG_ENABLED      = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_WRITE_BUFFER = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_BLANK1_FIRST = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_BLANK1_LAST  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_LATCH_FIRST  = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CFG_LATCH_LAST   = 3'd5;
  localparam logic [CfgIdxWidth-1:0] CFG_BLANK2_FIRST = 3'd6;
  localparam logic [CfgIdxWidth-1:0] CFG_BLANK2_LAST  = 3'd7;

  // Reset values of the column windows
  localparam logic [ColCfgWidth-1:0] RST_BLANK1_FIRST = 8'd0;
  localparam logic [ColCfgWidth-1:0] RST_BLANK1_LAST  = 8'd0;
  localparam logic [ColCfgWidth-1:0] RST_LATCH_FIRST  = 8'd63;
  localparam logic [ColCfgWidth-1:0] RST_LATCH_LAST   = 8'd63;
  localparam logic [ColCfgWidth-1:0] RST_BLANK2_FIRST = 8'd62;
  localparam logic [ColCfgWidth-1:0] RST_BLANK2_LAST  = 8'd62;

  localparam logic STATUS_WRITTEN  = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  typedef struct packed {
    logic                   enabled;
    logic                   write_buffer;
    logic [ColCfgWidth-1:0] blank1_first_col;
    logic [ColCfgWidth-1:0] blank1_last_col;
    logic [ColCfgWidth-1:0] latch_first_col;
    logic [ColCfgWidth-1:0] latch_last_col;
    logic [ColCfgWidth-1:0] blank2_first_col;
    logic [ColCfgWidth-1:0] blank2_last_col;
  } cfg_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] pixel_x;
    logic signed [CoordWidth-1:0] pixel_y;
    logic [LevelWidth-1:0]        red_level;
    logic [LevelWidth-1:0]        green_level;
    logic [LevelWidth-1:0]        blue_level;
  } pixel_t;

  typedef struct packed {
    logic                 status;
    logic [2:0]           plane;
    logic [3:0]           scan_row;
    logic [5:0]           stored_col;
    logic                 buffer_sel;
    logic [WordWidth-1:0] word;
    logic                 last;
  } result_t;

  // Drive word: {row address A..E, OE, LAT, lane 2 RGB, lane 1 RGB}
  typedef struct packed {
    logic [RowAddrWidth-1:0] row_addr;
    logic                    oe;
    logic                    lat;
    logic [LaneWidth-1:0]    lane2;
    logic [LaneWidth-1:0]    lane1;
  } drive_word_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } state_t;

  localparam result_t REJECT_RESULT = '{
    status:     STATUS_REJECTED,
    plane:      '0,
    scan_row:   '0,
    stored_col: '0,
    buffer_sel: 1'b0,
    word:       '0,
    last:       1'b1
  };

endpackage

@@ rtl/lmbpw_pixel_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmbpw_pixel_if
// Valid/ready channel carrying one pixel write.
// ----------------------------------------------------------------------------
interface lmbpw_pixel_if;
  logic              valid;
  logic              ready;
  lmbpw_pkg::pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/lmbpw_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmbpw_result_if
// Valid/ready channel carrying one written drive word or a reject status.
// ----------------------------------------------------------------------------
interface lmbpw_result_if;
  logic               valid;
  logic               ready;
  lmbpw_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/lmbpw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmbpw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lmbpw_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/lmbpw_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmbpw_cfg
// Configuration register file: enable, buffer select and column windows.
// ----------------------------------------------------------------------------
module lmbpw_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lmbpw_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  logic [lmbpw_pkg::ColCfgWidth-1:0]   cfg_data,
  output lmbpw_pkg::cfg_t                     cfg
);

  lmbpw_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.enabled          <= 1'b1;
      regs.write_buffer     <= 1'b0;
      regs.blank1_first_col <= lmbpw_pkg::RST_BLANK1_FIRST;
      regs.blank1_last_col  <= lmbpw_pkg::RST_BLANK1_LAST;
      regs.latch_first_col  <= lmbpw_pkg::RST_LATCH_FIRST;
      regs.latch_last_col   <= lmbpw_pkg::RST_LATCH_LAST;
      regs.blank2_first_col <= lmbpw_pkg::RST_BLANK2_FIRST;
      regs.blank2_last_col  <= lmbpw_pkg::RST_BLANK2_LAST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lmbpw_pkg::CFG_ENABLED:      regs.enabled          <= cfg_data[0];
        lmbpw_pkg::CFG_WRITE_BUFFER: regs.write_buffer     <= cfg_data[0];
        lmbpw_pkg::CFG_BLANK1_FIRST: regs.blank1_first_col <= cfg_data;
        lmbpw_pkg::CFG_BLANK1_LAST:  regs.blank1_last_col  <= cfg_data;
        lmbpw_pkg::CFG_LATCH_FIRST:  regs.latch_first_col  <= cfg_data;
        lmbpw_pkg::CFG_LATCH_LAST:   regs.latch_last_col   <= cfg_data;
        lmbpw_pkg::CFG_BLANK2_FIRST: regs.blank2_first_col <= cfg_data;
        lmbpw_pkg::CFG_BLANK2_LAST:  regs.blank2_last_col  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

@@ rtl/lmbpw_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmbpw_engine
// Pixel write sequencer: zeroes the frame store after reset, checks the write,
// then runs one read-modify-write of the frame store per bitplane and hands
// each word to the result register; a rejected write gets a reject result.
module lmbpw_engine #(
  parameter int PANEL_WIDTH  = 64,
  parameter int PANEL_HEIGHT = 32,
  parameter int HALF_ROWS    = 16,
  parameter int PLANES       = 8,
  localparam int STORE_DEPTH = 2 * HALF_ROWS * PLANES * PANEL_WIDTH,
  localparam int AW          = $clog2(STORE_DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lmbpw_pkg::cfg_t                     cfg,
  lmbpw_pixel_if.sink                         pix,
  lmbpw_result_if.source                      res,
  output logic                                ram_we,
  output logic [AW-1:0]                       ram_waddr,
  output logic [lmbpw_pkg::WordWidth-1:0]     ram_wdata,
  output logic                                ram_re,
  output logic [AW-1:0]                       ram_raddr,
  input  logic [lmbpw_pkg::WordWidth-1:0]     ram_rdata
);

  localparam int XW         = $clog2(PANEL_WIDTH);
  localparam int RW         = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
  localparam int RSW        = $clog2(2 * HALF_ROWS);
  localparam int PW         = (PLANES > 1) ? $clog2(PLANES) : 1;
  localparam int ROW_STRIDE = PLANES * PANEL_WIDTH;
  localparam int CW         = lmbpw_pkg::CoordWidth;

  lmbpw_pkg::state_t state, state_next;

  // Control
  logic          rd_pending;
  logic [AW-1:0] clr_addr;
  logic          res_valid;
  logic          res_load;
  lmbpw_pkg::result_t res_data, res_next;

  // Item context
  logic              ctx_buf;
  logic              ctx_lower;
  logic [RW-1:0]     ctx_row;
  logic [XW-1:0]     ctx_col;
  logic [PLANES-1:0] ctx_red, ctx_green, ctx_blue;
  logic              ctx_oe, ctx_lat;
  logic [AW-1:0]     addr;
  logic [PW-1:0]     pc;

  // Accept-side decode
  logic [CW-1:0]  x_u, y_u, y_adj, col16;
  logic           lower, in_range, accept_ok;
  logic [RSW-1:0] rowsel;
  logic [AW-1:0]  base;
  logic [lmbpw_pkg::ColCfgWidth-1:0] x8;
  logic           oe_hit, lat_hit;

  // Plane word
  logic                                   out_free, last_plane;
  logic [lmbpw_pkg::LaneWidth-1:0]        lane_new;
  logic [lmbpw_pkg::RowAddrWidth-1:0]     row5, addr5;
  lmbpw_pkg::drive_word_t                 old_word, word;

  logic pix_ready, start, step;

  always_comb begin
    x_u      = $unsigned(pix.data.pixel_x);
    y_u      = $unsigned(pix.data.pixel_y);
    in_range = cfg.enabled && !x_u[CW-1] && !y_u[CW-1]
               && (x_u < CW'(PANEL_WIDTH)) && (y_u < CW'(PANEL_HEIGHT));
    lower    = y_u >= CW'(HALF_ROWS);
    y_adj    = lower ? y_u - CW'(HALF_ROWS) : y_u;
    col16    = x_u ^ CW'(1);
    accept_ok = in_range && (y_adj < CW'(HALF_ROWS)) && (col16 < CW'(PANEL_WIDTH));
    rowsel   = RSW'(y_adj) + (cfg.write_buffer ? RSW'(HALF_ROWS) : RSW'(0));
    base     = AW'(rowsel) * AW'(ROW_STRIDE) + AW'(col16[XW-1:0]);
    x8       = x_u[lmbpw_pkg::ColCfgWidth-1:0];
    oe_hit   = (x8 >= cfg.blank1_first_col && x8 <= cfg.blank1_last_col)
               || (x8 >= cfg.blank2_first_col && x8 <= cfg.blank2_last_col);
    lat_hit  = x8 >= cfg.latch_first_col && x8 <= cfg.latch_last_col;
  end

  always_comb begin
    out_free   = !res_valid || res.ready;
    last_plane = pc == PW'(PLANES - 1);
    old_word   = ram_rdata;
    lane_new   = {ctx_blue[pc], ctx_green[pc], ctx_red[pc]};
    row5       = lmbpw_pkg::RowAddrWidth'(ctx_row);
    // Plane 0 carries the previous row's address
    addr5      = (pc == PW'(0)) ? row5 - 5'd1 : row5;
    word.row_addr = addr5;
    word.oe       = ctx_oe;
    word.lat      = ctx_lat;
    word.lane2    = ctx_lower ? lane_new : old_word.lane2;
    word.lane1    = ctx_lower ? old_word.lane1 : lane_new;
  end

  always_comb begin
    state_next = state;
    pix_ready  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = addr;
    ram_wdata  = word;
    ram_re     = 1'b0;
    ram_raddr  = addr;
    res_load   = 1'b0;
    start      = 1'b0;
    step       = 1'b0;
    res_next.status     = lmbpw_pkg::STATUS_WRITTEN;
    res_next.plane      = 3'(pc);
    res_next.scan_row   = 4'(ctx_row);
    res_next.stored_col = 6'(ctx_col);
    res_next.buffer_sel = ctx_buf;
    res_next.word       = word;
    res_next.last       = last_plane;
    unique case (state)
      lmbpw_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == AW'(STORE_DEPTH - 1)) begin
          state_next = lmbpw_pkg::ST_IDLE;
        end
      end
      lmbpw_pkg::ST_IDLE: begin
        pix_ready = out_free;
        if (pix.valid && out_free) begin
          if (accept_ok) begin
            start      = 1'b1;
            state_next = lmbpw_pkg::ST_RUN;
          end else begin
            res_load = 1'b1;
            res_next = lmbpw_pkg::REJECT_RESULT;
          end
        end
      end
      lmbpw_pkg::ST_RUN: begin
        if (!rd_pending) begin
          ram_re = 1'b1;
        end else if (out_free) begin
          ram_we   = 1'b1;
          res_load = 1'b1;
          step     = 1'b1;
          if (last_plane) begin
            state_next = lmbpw_pkg::ST_IDLE;
          end else begin
            // Fetch the next plane while this one is written back
            ram_re    = 1'b1;
            ram_raddr = addr + AW'(PANEL_WIDTH);
          end
        end
      end
      default: state_next = lmbpw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lmbpw_pkg::ST_CLEAR;
      clr_addr   <= '0;
      rd_pending <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lmbpw_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (ram_re) begin
        rd_pending <= 1'b1;
      end else if (step) begin
        rd_pending <= 1'b0;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ctx_buf   <= cfg.write_buffer;
      ctx_lower <= lower;
      ctx_row   <= RW'(y_adj);
      ctx_col   <= col16[XW-1:0];
      ctx_red   <= pix.data.red_level[PLANES-1:0];
      ctx_green <= pix.data.green_level[PLANES-1:0];
      ctx_blue  <= pix.data.blue_level[PLANES-1:0];
      ctx_oe    <= oe_hit;
      ctx_lat   <= lat_hit;
      addr      <= base;
      pc        <= '0;
    end else if (step) begin
      pc   <= pc + PW'(1);
      addr <= addr + AW'(PANEL_WIDTH);
    end
    if (res_load) begin
      res_data <= res_next;
    end
  end

  assign pix.ready = pix_ready;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == lmbpw_pkg::ST_CLEAR) |-> !pix_ready)
    else $error("pixel accepted during store clear");

  a_write_needs_read: assert property (@(posedge clk) disable iff (rst)
    (state == lmbpw_pkg::ST_RUN && ram_we) |-> rd_pending)
    else $error("plane written back without its read data");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result register overwritten while held");

  a_plane_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == lmbpw_pkg::ST_RUN) |-> (pc <= PW'(PLANES - 1)))
    else $error("plane counter beyond last plane");

  a_run_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    (state == lmbpw_pkg::ST_RUN && state_next == lmbpw_pkg::ST_IDLE)
      |-> (res_load && res_next.last))
    else $error("write sequence ended without last result");

endmodule

@@ rtl/led_matrix_bitplane_pixel_writer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_bitplane_pixel_writer
// Pixel writer into a two-buffer bitplane framebuffer for an LED panel.
// ----------------------------------------------------------------------------
// Usage:
//   pix carries pixel writes (x, y, 8-bit red, green, blue); res returns one
//   drive word per bitplane, plane 0 first, last set on the final one. A
//   write that is disabled or off the panel returns a single result with
//   status set and last set, and leaves the store alone.
//   cfg_we/cfg_index/cfg_data write the eight configuration registers; write
//   them only while no pixel write is in flight.
//   Each accepted write runs one read-modify-write of the frame store RAM per
//   plane, pipelined so a plane's read overlaps the previous plane's write.
//   pix is not ready while an accepted write's planes are in progress; the
//   first word reaches res through the RAM read register and the result
//   register. A rejected write loads its result directly from idle.
//   After reset the store is swept to zero, one word a cycle, over all
//   2 * HALF_ROWS * PLANES * PANEL_WIDTH words (16384 by default); pix is
//   not ready during the sweep. Configuration resets to its defaults.
//   When res stalls, the sequence holds with the pending read data kept in
//   the RAM output register and resumes on the next transfer.
// ----------------------------------------------------------------------------
module led_matrix_bitplane_pixel_writer #(
  parameter int PANEL_WIDTH  = 64,
  parameter int PANEL_HEIGHT = 32,
  parameter int HALF_ROWS    = 16,
  parameter int PLANES       = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  lmbpw_pixel_if.sink                       pix,
  lmbpw_result_if.source                    res,
  input  logic                              cfg_we,
  input  logic [lmbpw_pkg::CfgIdxWidth-1:0] cfg_index,
  input  logic [lmbpw_pkg::ColCfgWidth-1:0] cfg_data
);

  localparam int STORE_DEPTH = 2 * HALF_ROWS * PLANES * PANEL_WIDTH;
  localparam int AW          = $clog2(STORE_DEPTH);

  lmbpw_pkg::cfg_t                  cfg;
  logic                             ram_we, ram_re;
  logic [AW-1:0]                    ram_waddr, ram_raddr;
  logic [lmbpw_pkg::WordWidth-1:0]  ram_wdata, ram_rdata;

  lmbpw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lmbpw_engine #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .HALF_ROWS    (HALF_ROWS),
    .PLANES       (PLANES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix       (pix),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  lmbpw_ram #(
    .WIDTH (lmbpw_pkg::WordWidth),
    .DEPTH (STORE_DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
